@@ rtl/isr_pkg.sv @@
// Shared types, widths and the seed table for the 64-bit integer square root.
package isr_pkg;

    // Widths of the data path
    localparam int RAD_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int SH_W    = 6;
    localparam int HALF_W  = 5;
    localparam int DVD_W   = 47;
    localparam int DSR_W   = 18;
    localparam int QUO_W   = 32;
    localparam int SEED_W  = 8;
    localparam int SEED_N  = 192;
    localparam int SEED_IW = 8;

    // Bit positions used to cut the normalized value
    localparam int TOP_LSB = 56;
    localparam int D1_LSB  = 41;
    localparam int D2_LSB  = 17;
    localparam int EST1_SH = 7;
    localparam int EST2_SH = 15;
    localparam logic [SEED_IW-1:0] SEED_BASE = 8'd64;

    // Word that rides along with a division
    typedef struct packed {
        logic                zero;
        logic [RAD_W-1:0]    norm;
        logic [HALF_W-1:0]   half;
        logic [ROOT_W-1:0]   est;
    } side_t;

    // seed[k] = floor(sqrt(256 * (k + 65) - 1))
    localparam logic [SEED_W-1:0] SEED_ROM [SEED_N] = '{
        8'd128, 8'd129, 8'd130, 8'd131, 8'd132, 8'd133, 8'd134, 8'd135,
        8'd136, 8'd137, 8'd138, 8'd139, 8'd140, 8'd141, 8'd142, 8'd143,
        8'd143, 8'd144, 8'd145, 8'd146, 8'd147, 8'd148, 8'd149, 8'd150,
        8'd150, 8'd151, 8'd152, 8'd153, 8'd154, 8'd155, 8'd155, 8'd156,
        8'd157, 8'd158, 8'd159, 8'd159, 8'd160, 8'd161, 8'd162, 8'd163,
        8'd163, 8'd164, 8'd165, 8'd166, 8'd167, 8'd167, 8'd168, 8'd169,
        8'd170, 8'd170, 8'd171, 8'd172, 8'd173, 8'd173, 8'd174, 8'd175,
        8'd175, 8'd176, 8'd177, 8'd178, 8'd178, 8'd179, 8'd180, 8'd181,
        8'd181, 8'd182, 8'd183, 8'd183, 8'd184, 8'd185, 8'd185, 8'd186,
        8'd187, 8'd187, 8'd188, 8'd189, 8'd189, 8'd190, 8'd191, 8'd191,
        8'd192, 8'd193, 8'd193, 8'd194, 8'd195, 8'd195, 8'd196, 8'd197,
        8'd197, 8'd198, 8'd199, 8'd199, 8'd200, 8'd201, 8'd201, 8'd202,
        8'd203, 8'd203, 8'd204, 8'd204, 8'd205, 8'd206, 8'd206, 8'd207,
        8'd207, 8'd208, 8'd209, 8'd209, 8'd210, 8'd211, 8'd211, 8'd212,
        8'd212, 8'd213, 8'd214, 8'd214, 8'd215, 8'd215, 8'd216, 8'd217,
        8'd217, 8'd218, 8'd218, 8'd219, 8'd219, 8'd220, 8'd221, 8'd221,
        8'd222, 8'd222, 8'd223, 8'd223, 8'd224, 8'd225, 8'd225, 8'd226,
        8'd226, 8'd227, 8'd227, 8'd228, 8'd229, 8'd229, 8'd230, 8'd230,
        8'd231, 8'd231, 8'd232, 8'd232, 8'd233, 8'd234, 8'd234, 8'd235,
        8'd235, 8'd236, 8'd236, 8'd237, 8'd237, 8'd238, 8'd238, 8'd239,
        8'd239, 8'd240, 8'd241, 8'd241, 8'd242, 8'd242, 8'd243, 8'd243,
        8'd244, 8'd244, 8'd245, 8'd245, 8'd246, 8'd246, 8'd247, 8'd247,
        8'd248, 8'd248, 8'd249, 8'd249, 8'd250, 8'd250, 8'd251, 8'd251,
        8'd252, 8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd255, 8'd255
    };

    // Leading-zero count of a nonzero word
    function automatic logic [SH_W-1:0] lead_zeros(input logic [RAD_W-1:0] v);
        logic [SH_W-1:0] n;
        n = '0;
        for (int i = 0; i < RAD_W; i++)
        begin
            if (v[i])
            begin
                n = SH_W'(RAD_W - 1 - i);
            end
        end
        return n;
    endfunction

endpackage

@@ rtl/isr_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with a side word.
module isr_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_vld,
    input  logic [isr_pkg::DVD_W-1:0]  dividend,
    input  logic [isr_pkg::DSR_W-1:0]  divisor,
    input  isr_pkg::side_t             in_side,
    output logic                       out_vld,
    output logic [isr_pkg::QUO_W-1:0]  quotient,
    output isr_pkg::side_t             out_side
);

    localparam int N = isr_pkg::DVD_W;
    localparam int W = isr_pkg::DSR_W;

    logic                       vld_reg  [N];
    logic [N-1:0]               dvd_reg  [N];
    logic [W-1:0]               dsr_reg  [N];
    logic [W-1:0]               rem_reg  [N];
    logic [isr_pkg::QUO_W-1:0]  quo_reg  [N];
    isr_pkg::side_t             side_reg [N];

    logic                       src_vld  [N];
    logic [N-1:0]               src_dvd  [N];
    logic [W-1:0]               src_dsr  [N];
    logic [W-1:0]               src_rem  [N];
    logic [isr_pkg::QUO_W-1:0]  src_quo  [N];
    isr_pkg::side_t             src_side [N];

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            logic [W:0]   trial;
            logic         fits;
            logic [W-1:0] rem_next;

            // Pick up the word from the port or the stage before
            if (k == 0)
            begin : g_first
                assign src_vld[k]  = in_vld;
                assign src_dvd[k]  = dividend;
                assign src_dsr[k]  = divisor;
                assign src_rem[k]  = '0;
                assign src_quo[k]  = '0;
                assign src_side[k] = in_side;
            end
            else
            begin : g_next
                assign src_vld[k]  = vld_reg[k-1];
                assign src_dvd[k]  = dvd_reg[k-1];
                assign src_dsr[k]  = dsr_reg[k-1];
                assign src_rem[k]  = rem_reg[k-1];
                assign src_quo[k]  = quo_reg[k-1];
                assign src_side[k] = side_reg[k-1];
            end

            // Shift in one dividend bit, subtract if the divisor fits
            assign trial    = {src_rem[k], src_dvd[k][N-1]};
            assign fits     = (trial >= {1'b0, src_dsr[k]});
            assign rem_next = fits ? W'(trial - {1'b0, src_dsr[k]}) : W'(trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= src_vld[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dvd_reg[k]  <= {src_dvd[k][N-2:0], 1'b0};
                    dsr_reg[k]  <= src_dsr[k];
                    rem_reg[k]  <= rem_next;
                    quo_reg[k]  <= {src_quo[k][isr_pkg::QUO_W-2:0], fits};
                    side_reg[k] <= src_side[k];
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[N-1];
    assign quotient = quo_reg[N-1];
    assign out_side = side_reg[N-1];

endmodule

@@ rtl/integer_square_root_64.sv @@
// Top level of the pipelined 64-bit integer square root.
//
// Takes one 64-bit radicand per cycle while in_stall is low and returns its
// 32-bit integer square root through two normalization stages, two
// 47-stage dividers with one stage each after them, a multiply stage and
// the output register. The two Newton dividers give one quotient bit per
// stage. The whole pipeline holds while out_stall keeps a result waiting,
// and in_stall follows it; zero radicands give zero.
module integer_square_root_64 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [isr_pkg::RAD_W-1:0]     radicand,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [isr_pkg::ROOT_W-1:0]    root
);

    logic en;

    // Stage 1: zero detect and leading-zero count
    logic                          s1_vld_reg;
    logic                          s1_zero_reg;
    logic [isr_pkg::RAD_W-1:0]     s1_v_reg;
    logic [isr_pkg::SH_W-1:0]      s1_sh_reg;

    // Stage 2: normalize and seed lookup
    logic                          s2_vld_reg;
    isr_pkg::side_t                s2_side_reg;
    logic [isr_pkg::SEED_W-1:0]    s2_seed_reg;
    logic [isr_pkg::RAD_W-1:0]     s2_norm_next;
    logic [isr_pkg::SEED_IW-1:0]   s2_top;
    logic [isr_pkg::SEED_IW-1:0]   s2_idx;
    isr_pkg::side_t                s2_side_next;

    // First division
    logic                          d1_vld;
    logic [isr_pkg::QUO_W-1:0]     d1_quo;
    isr_pkg::side_t                d1_side;
    isr_pkg::side_t                d1_in_side;

    // Stage 3: first Newton sum
    logic                          s3_vld_reg;
    isr_pkg::side_t                s3_side_reg;
    isr_pkg::side_t                s3_side_next;

    // Second division
    logic                          d2_vld;
    logic [isr_pkg::QUO_W-1:0]     d2_quo;
    isr_pkg::side_t                d2_side;

    // Stage 4: second Newton sum
    logic                          s4_vld_reg;
    isr_pkg::side_t                s4_side_reg;
    isr_pkg::side_t                s4_side_next;

    // Stage 5: square of the estimate
    logic                          s5_vld_reg;
    isr_pkg::side_t                s5_side_reg;
    logic [isr_pkg::RAD_W-1:0]     s5_sq_reg;

    // Stage 6: correction and denormalize into the output register
    logic                          out_vld_reg;
    logic [isr_pkg::ROOT_W-1:0]    root_reg;
    logic [isr_pkg::ROOT_W-1:0]    fix_est;

    // Advance everything unless a finished word is held
    assign en       = !(out_vld_reg && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= in_valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= d1_vld;
            s4_vld_reg  <= d2_vld;
            s5_vld_reg  <= s4_vld_reg;
            out_vld_reg <= s5_vld_reg;
        end
    end

    // Stage 1
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_v_reg    <= radicand;
            s1_zero_reg <= (radicand == '0);
            s1_sh_reg   <= isr_pkg::lead_zeros(radicand) & 6'b111110;
        end
    end

    // Stage 2
    always_comb
    begin
        s2_norm_next      = s1_v_reg << s1_sh_reg;
        s2_top            = s2_norm_next[isr_pkg::RAD_W-1:isr_pkg::TOP_LSB];
        s2_idx            = (s2_top >= isr_pkg::SEED_BASE) ?
                            (s2_top - isr_pkg::SEED_BASE) : '0;
        s2_side_next.zero = s1_zero_reg;
        s2_side_next.norm = s2_norm_next;
        s2_side_next.half = s1_sh_reg[isr_pkg::SH_W-1:1];
        s2_side_next.est  = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_side_reg <= s2_side_next;
            s2_seed_reg <= isr_pkg::SEED_ROM[s2_idx];
        end
    end

    // Divide the top bits by the seed
    always_comb
    begin
        d1_in_side     = s2_side_reg;
        d1_in_side.est = isr_pkg::ROOT_W'(s2_seed_reg);
    end

    isr_div u_div1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s2_vld_reg),
        .dividend (isr_pkg::DVD_W'(s2_side_reg.norm[isr_pkg::RAD_W-1:isr_pkg::D1_LSB])),
        .divisor  (isr_pkg::DSR_W'(s2_seed_reg)),
        .in_side  (d1_in_side),
        .out_vld  (d1_vld),
        .quotient (d1_quo),
        .out_side (d1_side)
    );

    // Stage 3
    always_comb
    begin
        s3_side_next     = d1_side;
        s3_side_next.est = (d1_side.est << isr_pkg::EST1_SH) + d1_quo;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_side_reg <= s3_side_next;
        end
    end

    // Divide the wider slice by the first estimate, cut to the 18-bit divisor width
    isr_div u_div2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s3_vld_reg),
        .dividend (s3_side_reg.norm[isr_pkg::RAD_W-1:isr_pkg::D2_LSB]),
        .divisor  (s3_side_reg.est[isr_pkg::DSR_W-1:0]),
        .in_side  (s3_side_reg),
        .out_vld  (d2_vld),
        .quotient (d2_quo),
        .out_side (d2_side)
    );

    // Stage 4
    always_comb
    begin
        s4_side_next     = d2_side;
        s4_side_next.est = (d2_side.est << isr_pkg::EST2_SH) + d2_quo;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_side_reg <= s4_side_next;
        end
    end

    // Stage 5
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_side_reg <= s4_side_reg;
            s5_sq_reg   <= isr_pkg::RAD_W'(s4_side_reg.est) *
                           isr_pkg::RAD_W'(s4_side_reg.est);
        end
    end

    // Stage 6: drop one when the square overshoots, then undo the shift
    assign fix_est = (s5_side_reg.norm < s5_sq_reg) ?
                     (s5_side_reg.est - isr_pkg::ROOT_W'(1)) : s5_side_reg.est;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_reg <= s5_side_reg.zero ? '0 : (fix_est >> s5_side_reg.half);
        end
    end

    assign out_valid = out_vld_reg;
    assign root      = root_reg;

    // Normalization leaves one of the two top bits set
    a_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_vld_reg && !s2_side_reg.zero) |->
        (s2_side_reg.norm[isr_pkg::RAD_W-1] || s2_side_reg.norm[isr_pkg::RAD_W-2]))
        else $error("normalized radicand lacks a top bit");

    // Seeds of normalized values are at least 128
    a_seed: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_vld_reg && !s2_side_reg.zero) |-> s2_seed_reg[isr_pkg::SEED_W-1])
        else $error("seed below range");

    // First estimate fits the second divider's divisor width
    a_est1: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_vld_reg && !s3_side_reg.zero) |->
        (s3_side_reg.est[isr_pkg::ROOT_W-1:isr_pkg::DSR_W] == '0))
        else $error("first estimate too wide");

endmodule

@@ test/tb_integer_square_root_64.sv @@
// Testbench for the pipelined 64-bit integer square root.
module tb_integer_square_root_64;

    localparam int LATENCY     = 100;
    localparam int CYCLE_LIMIT = 400000;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [isr_pkg::RAD_W-1:0]  radicand;
    logic                       out_valid;
    logic                       out_stall;
    logic [isr_pkg::ROOT_W-1:0] root;

    logic [isr_pkg::ROOT_W-1:0] roots_due[$];
    int                         error_count;
    int                         cycle_count;
    int                         out_wait;

    integer_square_root_64 u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .radicand  (radicand),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .root      (root)
    );

    // Toggle the clock every half period
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Compute the expected root: normalize, seed, two Newton steps, correct
    function automatic logic [isr_pkg::ROOT_W-1:0] predict_root(
        input logic [isr_pkg::RAD_W-1:0] v);
        int                           norm_sh;
        logic [isr_pkg::RAD_W-1:0]    norm;
        logic [7:0]                   top;
        logic [7:0]                   seed_idx;
        logic [isr_pkg::ROOT_W-1:0]   est;
        logic [isr_pkg::RAD_W-1:0]    quo;
        logic [2*isr_pkg::ROOT_W-1:0] sq;
        if (v == '0)
        begin
            return '0;
        end
        norm_sh = 0;
        while (!v[63 - norm_sh])
        begin
            norm_sh++;
        end
        norm_sh = norm_sh & 62;
        norm = v << norm_sh;
        top = norm[63:56];
        seed_idx = (top >= 8'd64) ? top - 8'd64 : 8'd0;
        est = isr_pkg::ROOT_W'(isr_pkg::SEED_ROM[seed_idx]);
        quo = (norm >> 41) / est;
        est = (est << 7) + quo[isr_pkg::ROOT_W-1:0];
        if (est == '0)
        begin
            est = isr_pkg::ROOT_W'(1);
        end
        quo = (norm >> 17) / est;
        est = (est << 15) + quo[isr_pkg::ROOT_W-1:0];
        sq = isr_pkg::RAD_W'(est) * isr_pkg::RAD_W'(est);
        if (norm < sq)
        begin
            est = est - isr_pkg::ROOT_W'(1);
        end
        return est >> (norm_sh >> 1);
    endfunction

    // Send one word, with a random gap before it
    task automatic send_word(input logic [isr_pkg::RAD_W-1:0] v, input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        radicand <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        roots_due.push_back(predict_root(v));
        @(negedge clk);
    endtask

    task automatic test_extremes();
        send_word(64'd0);
        send_word(64'd1);
        send_word(64'd2);
        send_word(64'd3);
        send_word(64'd4);
        send_word(64'hFFFF_FFFF_FFFF_FFFF);
        send_word(64'hFFFF_FFFE_0000_0001);
        send_word(64'hFFFF_FFFE_0000_0000);
        send_word(64'h8000_0000_0000_0000);
        send_word(64'h4000_0000_0000_0000);
        send_word(64'h7FFF_FFFF_FFFF_FFFF);
        send_word(64'h3FFF_FFFF_FFFF_FFFF);
        send_word(64'h0000_0001_0000_0000);
        send_word(64'h0000_0000_FFFF_FFFF);
        send_word(64'hAAAA_AAAA_AAAA_AAAA);
        send_word(64'h5555_5555_5555_5555);
    endtask

    // Perfect squares and their neighbors exercise the downward correction
    task automatic test_squares();
        logic [31:0] r;
        logic [63:0] sq;
        for (int i = 0; i < 150; i++)
        begin
            r = $urandom();
            r = r >> $urandom_range(0, 31);
            sq = 64'(r) * 64'(r);
            case ($urandom_range(0, 2))
                0: send_word(sq);
                1: send_word(sq - 1);
                default: send_word(sq + 1);
            endcase
        end
    endtask

    // Random words at every magnitude, some back to back
    task automatic test_random(input int count);
        logic [63:0] v;
        for (int i = 0; i < count; i++)
        begin
            v = {$urandom(), $urandom()};
            v = v >> $urandom_range(0, 63);
            send_word(v, ($urandom_range(0, 3) == 0));
        end
    endtask

    // Hold off until the pipeline drains, then send 50 random words
    task automatic test_drain_pause();
        in_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (roots_due.size() != 0);
        test_random(50);
    endtask

    // Hold the output stall for a drawn number of cycles after each word
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_wait = 0;
            out_stall <= 1'b0;
        end
        else if (out_wait > 0)
        begin
            out_wait--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (out_valid)
            begin
                out_wait = $urandom_range(0, 6);
            end
        end
    end

    // Check each accepted result against the oldest expected root
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (roots_due.size() == 0)
            begin
                $error("root: unexpected result %0d", root);
                error_count++;
            end
            else
            begin
                logic [isr_pkg::ROOT_W-1:0] want;
                want = roots_due.pop_front();
                if (root !== want)
                begin
                    $error("root: expected %0d actual %0d", want, root);
                    error_count++;
                end
            end
        end
    end

    // Stop on the cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        error_count  = 0;
        cycle_count  = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        radicand  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_extremes();
        test_squares();
        test_random(500);
        test_drain_pause();
        test_random(500);
        in_valid <= 1'b0;
        while (roots_due.size() != 0) @(negedge clk);
        repeat (LATENCY + 20) @(negedge clk);
        if (error_count == 0 && roots_due.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/isr_pkg.sv
rtl/isr_div.sv
rtl/integer_square_root_64.sv
test/tb_integer_square_root_64.sv
